>>> sv/vagadpcm_pkg.sv
`timescale 1ns / 1ps

package vagadpcm_pkg;

  localparam int BLOCK_INDEX_BITS_DEFAULT = 24;
  localparam int BLOCK_COUNT_W            = 24;
  localparam int SAMPLE_W                 = 16;
  localparam int QUEUE_DEPTH              = 2;

  // register index, taken from paddr[2]
  localparam logic REG_LOOP_ENABLE = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE  = 2'b00,   // header, flag or ignored byte: no samples
    OP_DATA  = 2'b01,   // data byte: two samples
    OP_CLEAR = 2'b10    // key on: history back to zero
  } op_t;

  // one classified byte, handed from the front to the back
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [3:0] predictor;
    logic [3:0] shift;
    logic       ended;
    logic       done;
  } entry_t;

  // prediction weight on the most recent sample
  function automatic logic [7:0] coef_recent(input logic [3:0] sel);
    logic [7:0] c;
    unique case (sel)
      4'd1:    c = 8'd60;
      4'd2:    c = 8'd115;
      4'd3:    c = 8'd98;
      4'd4:    c = 8'd122;
      4'd7:    c = 8'd52;
      4'd8:    c = 8'd55;
      4'd9:    c = 8'd60;
      4'd13:   c = 8'd2;
      4'd14:   c = 8'd125;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // weight on the older sample, subtracted
  function automatic logic [7:0] coef_older(input logic [3:0] sel);
    logic [7:0] c;
    unique case (sel)
      4'd2:    c = 8'd52;
      4'd3:    c = 8'd55;
      4'd4:    c = 8'd60;
      4'd8:    c = 8'd2;
      4'd9:    c = 8'd125;
      4'd11:   c = 8'd91;
      4'd13:   c = 8'd216;
      4'd14:   c = 8'd6;
      4'd15:   c = 8'd151;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

>>> sv/vagadpcm_if.sv
`timescale 1ns / 1ps

interface vagadpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       key_on;

  modport source (output valid, output data_byte, output key_on, input ready);
  modport sink   (input valid, input data_byte, input key_on, output ready);
endinterface

interface vagadpcm_out_if #(
  parameter int BLOCK_INDEX_BITS = vagadpcm_pkg::BLOCK_INDEX_BITS_DEFAULT
);
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          sample_first;
  logic signed [15:0]          sample_second;
  logic                        sample_valid;
  logic                        stream_ended;
  logic                        block_done;
  logic [BLOCK_INDEX_BITS-1:0] next_block;

  modport source (output valid, output sample_first, output sample_second,
                  output sample_valid, output stream_ended, output block_done,
                  output next_block, input ready);
  modport sink   (input valid, input sample_first, input sample_second,
                  input sample_valid, input stream_ended, input block_done,
                  input next_block, output ready);
endinterface

>>> sv/vagadpcm_queue.sv
`timescale 1ns / 1ps

module vagadpcm_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/vagadpcm_front.sv
`timescale 1ns / 1ps

module vagadpcm_front #(
  parameter int BLOCK_INDEX_BITS = vagadpcm_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  vagadpcm_in_if.sink                             stream,
  input  logic                                    loop_enable,
  input  logic [vagadpcm_pkg::BLOCK_COUNT_W-1:0]  block_count,
  input  logic                                    q_full,
  output logic                                    q_push,
  output vagadpcm_pkg::entry_t                    q_entry,
  output logic [BLOCK_INDEX_BITS-1:0]             q_next_block
);

  import vagadpcm_pkg::*;

  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_DATA   = 4'd2;
  localparam logic [3:0] POS_LAST   = 4'd15;

  localparam logic [7:0] FLAG_END        = 8'd7;
  localparam logic [7:0] FLAG_LOOP_START = 8'd6;
  localparam logic [7:0] FLAG_LOOP_REQ   = 8'd3;

  localparam int CmpW = (BLOCK_INDEX_BITS > BLOCK_COUNT_W) ? BLOCK_INDEX_BITS : BLOCK_COUNT_W;

  logic [3:0]                  byte_position, byte_position_next;
  logic [3:0]                  predictor_select, predictor_select_next;
  logic [3:0]                  shift_amount, shift_amount_next;
  logic [BLOCK_INDEX_BITS-1:0] blocks_started, blocks_started_next;
  logic [BLOCK_INDEX_BITS-1:0] loop_target, loop_target_next;
  logic                        loop_pending, loop_pending_next;
  logic                        ended_flag, ended_flag_next;
  logic                        count_reached;
  logic                        accept;

  assign stream.ready = !q_full;
  assign accept       = stream.valid && !q_full;
  assign q_push       = accept;

  assign count_reached = (CmpW'(blocks_started) >= CmpW'(block_count));

  always_comb begin
    byte_position_next    = byte_position;
    predictor_select_next = predictor_select;
    shift_amount_next     = shift_amount;
    blocks_started_next   = blocks_started;
    loop_target_next      = loop_target;
    loop_pending_next     = loop_pending;
    ended_flag_next       = ended_flag;

    q_entry.op        = OP_NONE;
    q_entry.data_byte = stream.data_byte;
    q_entry.predictor = predictor_select;
    q_entry.shift     = shift_amount;
    q_entry.done      = 1'b0;

    priority if (stream.key_on) begin
      byte_position_next    = '0;
      predictor_select_next = '0;
      shift_amount_next     = '0;
      blocks_started_next   = '0;
      loop_target_next      = '0;
      loop_pending_next     = 1'b0;
      ended_flag_next       = 1'b0;
      q_entry.op            = OP_CLEAR;
    end else if (ended_flag) begin
      // stream over: byte yields no samples
    end else begin
      unique case (byte_position)
        POS_HEADER: begin
          if (count_reached) begin
            ended_flag_next = 1'b1;
          end else begin
            predictor_select_next = stream.data_byte[7:4];
            shift_amount_next     = stream.data_byte[3:0];
            byte_position_next    = POS_FLAGS;
          end
        end
        POS_FLAGS: begin
          if (stream.data_byte == FLAG_END) begin
            ended_flag_next = 1'b1;
          end else begin
            if (stream.data_byte == FLAG_LOOP_START) begin
              loop_target_next = blocks_started;
            end else if (stream.data_byte == FLAG_LOOP_REQ && loop_enable) begin
              loop_pending_next = 1'b1;
            end
            byte_position_next = POS_DATA;
          end
        end
        default: begin
          q_entry.op = OP_DATA;
          if (byte_position == POS_LAST) begin
            q_entry.done        = 1'b1;
            blocks_started_next = loop_pending ? loop_target : blocks_started + 1'b1;
            loop_pending_next   = 1'b0;
            byte_position_next  = POS_HEADER;
          end else begin
            byte_position_next = byte_position + 1'b1;
          end
        end
      endcase
    end

    q_entry.ended = ended_flag_next;
    if (ended_flag_next || byte_position_next == POS_HEADER) begin
      q_next_block = blocks_started_next;
    end else begin
      q_next_block = loop_pending_next ? loop_target_next : blocks_started_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      predictor_select <= '0;
      shift_amount     <= '0;
      blocks_started   <= '0;
      loop_target      <= '0;
      loop_pending     <= 1'b0;
      ended_flag       <= 1'b0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      predictor_select <= predictor_select_next;
      shift_amount     <= shift_amount_next;
      blocks_started   <= blocks_started_next;
      loop_target      <= loop_target_next;
      loop_pending     <= loop_pending_next;
      ended_flag       <= ended_flag_next;
    end
  end

endmodule

>>> sv/vagadpcm_back.sv
`timescale 1ns / 1ps

module vagadpcm_back #(
  parameter int BLOCK_INDEX_BITS = vagadpcm_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  vagadpcm_pkg::entry_t        q_entry,
  input  logic [BLOCK_INDEX_BITS-1:0] q_next_block,
  output logic                        q_pop,
  vagadpcm_out_if.source              result
);

  import vagadpcm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state, state_next;

  entry_t                      work;
  logic [BLOCK_INDEX_BITS-1:0] work_next_block;
  logic                        phase;            // 0: low nibble, 1: high nibble
  logic signed [15:0]          hist_recent, hist_older;
  logic signed [15:0]          hist_recent_next, hist_older_next;
  logic signed [15:0]          op_recent, op_older;
  logic signed [24:0]          prod_recent, prod_older;
  logic signed [15:0]          first_s, second_s;

  logic [3:0]                  nibble;
  logic signed [15:0]          scaled;
  logic signed [25:0]          pred_diff;
  logic signed [19:0]          pred_sh;
  logic signed [20:0]          total;
  logic signed [15:0]          sample;
  logic signed [15:0]          second_out;

  logic                        finish;
  logic                        can_load;
  logic                        load;

  logic                        out_valid;
  logic signed [15:0]          out_first, out_second;
  logic                        out_sample_valid, out_ended, out_done;
  logic [BLOCK_INDEX_BITS-1:0] out_next_block;

  // one nibble through the two-tap predictor, clamped to 16 bits
  assign nibble    = phase ? work.data_byte[7:4] : work.data_byte[3:0];
  assign scaled    = $signed({nibble, 12'b0}) >>> work.shift;
  assign pred_diff = {prod_recent[24], prod_recent} - {prod_older[24], prod_older};
  assign pred_sh   = pred_diff[25:6];
  assign total     = {{5{scaled[15]}}, scaled} + {pred_sh[19], pred_sh};

  always_comb begin
    if (total > 21'sd32767) begin
      sample = 16'sh7fff;
    end else if (total < -21'sd32768) begin
      sample = 16'sh8000;
    end else begin
      sample = total[15:0];
    end
  end

  assign finish     = (state == ST_SUM && phase) || (state == ST_HOLD);
  assign can_load   = !out_valid || result.ready;
  assign load       = finish && can_load;
  assign q_pop      = !q_empty && ((state == ST_IDLE) || load);
  assign second_out = (state == ST_SUM) ? sample : second_s;

  // history as seen by the next byte
  always_comb begin
    hist_recent_next = hist_recent;
    hist_older_next  = hist_older;
    if (load) begin
      unique case (work.op)
        OP_DATA: begin
          hist_older_next  = first_s;
          hist_recent_next = second_out;
        end
        OP_CLEAR: begin
          hist_older_next  = '0;
          hist_recent_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_pop) state_next = (q_entry.op == OP_DATA) ? ST_MUL : ST_HOLD;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM: begin
        if (!phase) begin
          state_next = ST_MUL;
        end else if (!can_load) begin
          state_next = ST_HOLD;
        end else if (q_pop) begin
          state_next = (q_entry.op == OP_DATA) ? ST_MUL : ST_HOLD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!can_load) begin
          state_next = ST_HOLD;
        end else if (q_pop) begin
          state_next = (q_entry.op == OP_DATA) ? ST_MUL : ST_HOLD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      hist_recent <= '0;
      hist_older  <= '0;
    end else begin
      state       <= state_next;
      hist_recent <= hist_recent_next;
      hist_older  <= hist_older_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath: one multiplier pair, used once per nibble
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work            <= q_entry;
      work_next_block <= q_next_block;
      phase           <= 1'b0;
      op_recent       <= hist_recent_next;
      op_older        <= hist_older_next;
      first_s         <= '0;
      second_s        <= '0;
    end else if (state == ST_SUM) begin
      if (!phase) begin
        first_s   <= sample;
        op_recent <= sample;
        op_older  <= hist_recent;
        phase     <= 1'b1;
      end else begin
        second_s <= sample;
      end
    end
    if (state == ST_MUL) begin
      prod_recent <= 25'(op_recent) * 25'($signed({1'b0, coef_recent(work.predictor)}));
      prod_older  <= 25'(op_older) * 25'($signed({1'b0, coef_older(work.predictor)}));
    end
    if (load) begin
      out_first        <= first_s;
      out_second       <= second_out;
      out_sample_valid <= (work.op == OP_DATA);
      out_ended        <= work.ended;
      out_done         <= work.done;
      out_next_block   <= work_next_block;
    end
  end

  assign result.valid         = out_valid;
  assign result.sample_first  = out_first;
  assign result.sample_second = out_second;
  assign result.sample_valid  = out_sample_valid;
  assign result.stream_ended  = out_ended;
  assign result.block_done    = out_done;
  assign result.next_block    = out_next_block;

endmodule

>>> sv/vag_adpcm_block_decoder.sv
// Data byte: queued, then popped into the back end; each nibble takes a multiply and a sum
//   step on the multiplier pair, and the next byte is popped as its one result beat registers.
// Header, flag, key-on and post-end bytes: one result beat each, through the hold state.
// A 2-entry queue decouples byte intake from the back end; input stalls only when full.
// rst (synchronous, active high) clears decoder state, queue, output and both registers.
`timescale 1ns / 1ps

module vag_adpcm_block_decoder #(
  parameter int BLOCK_INDEX_BITS = vagadpcm_pkg::BLOCK_INDEX_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  vagadpcm_in_if.sink          stream,
  vagadpcm_out_if.source       result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import vagadpcm_pkg::*;

  localparam int QueueW = $bits(entry_t) + BLOCK_INDEX_BITS;

  // configuration registers
  logic                     loop_enable;
  logic [BLOCK_COUNT_W-1:0] block_count;
  logic                     cfg_write;

  // front-to-back queue
  logic                        q_push, q_pop, q_full, q_empty;
  entry_t                      push_entry, pop_entry;
  logic [BLOCK_INDEX_BITS-1:0] push_next_block, pop_next_block;
  logic [QueueW-1:0]           q_rdata;

  // APB: no wait states; register chosen by the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
      block_count <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LOOP_ENABLE: loop_enable <= pwdata[0];
        REG_BLOCK_COUNT: block_count <= pwdata[BLOCK_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOOP_ENABLE: prdata = {31'b0, loop_enable};
      REG_BLOCK_COUNT: prdata = 32'(block_count);
      default:         prdata = '0;
    endcase
  end

  // front: owns block position, flags, block index and end state
  vagadpcm_front #(
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream),
    .loop_enable  (loop_enable),
    .block_count  (block_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry),
    .q_next_block (push_next_block)
  );

  vagadpcm_queue #(
    .WIDTH (QueueW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({push_entry, push_next_block}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign pop_entry      = entry_t'(q_rdata[QueueW-1 -: $bits(entry_t)]);
  assign pop_next_block = q_rdata[BLOCK_INDEX_BITS-1:0];

  // back: sample history, prediction and the output register
  vagadpcm_back #(
    .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_entry      (pop_entry),
    .q_next_block (pop_next_block),
    .q_pop        (q_pop),
    .result       (result)
  );

endmodule
